### design/aopt_pkg.sv
// Shared types and constants for the onset/pitch note trigger.
// Used by the front end, job queue, back end and top level; no dependencies.
package aopt_pkg;

    localparam int SUM_W   = 48;
    localparam int CNT_W   = 16;
    localparam int FRM_W   = 14;
    localparam int LEVEL_W = 24;
    localparam int Q16_W   = 17;

    localparam logic [2:0] REG_BODY  = 3'd0;
    localparam logic [2:0] REG_EXC   = 3'd1;
    localparam logic [2:0] REG_MORPH = 3'd2;
    localparam logic [2:0] REG_SRATE = 3'd3;
    localparam logic [2:0] REG_WLEN  = 3'd4;

    localparam logic [0:0] EV_OFF = 1'b0;
    localparam logic [0:0] EV_ON  = 1'b1;

    typedef struct packed {
        logic signed [23:0] left_sample;
        logic signed [23:0] right_sample;
        logic               block_end;
    } t_in_word;

    typedef struct packed {
        logic        event_kind;
        logic [6:0]  note_number;
        logic [16:0] note_velocity;
        logic        last_event;
    } t_out_word;

    typedef struct packed {
        logic [16:0] body_size;
        logic [16:0] excite_level;
        logic [16:0] morph_amount;
        logic [17:0] sample_rate_hz;
        logic [12:0] window_length;
    } t_cfg;

    typedef struct packed {
        logic [SUM_W-1:0] sum;
        logic [FRM_W-1:0] n;
        logic [CNT_W-1:0] flips;
        logic [CNT_W-1:0] wlen;
    } t_job;

    // lower rounding edges of notes 36..47, Hz in Q.16
    function automatic logic [22:0] note_edge(input logic [3:0] k);
        logic [22:0] e;
        unique case (k)
            4'd0:    e = 23'd4164446;
            4'd1:    e = 23'd4412077;
            4'd2:    e = 23'd4674432;
            4'd3:    e = 23'd4952388;
            4'd4:    e = 23'd5246873;
            4'd5:    e = 23'd5558868;
            4'd6:    e = 23'd5889416;
            4'd7:    e = 23'd6239618;
            4'd8:    e = 23'd6610645;
            4'd9:    e = 23'd7003735;
            4'd10:   e = 23'd7420199;
            4'd11:   e = 23'd7861427;
            default: e = 23'd7861427;
        endcase
        return e;
    endfunction

endpackage

### design/aopt_ram.sv
// Generic simple dual-port RAM, one write port, one registered read port.
// No dependencies.
module aopt_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

### design/aopt_front.sv
// Front end: takes sample words, keeps the sign window and energy sum, counts
// zero crossings at block close if morph > 655 and hands a job on. Uses aopt_pkg, aopt_ram.
module aopt_front #(
    parameter int WINDOW_DEPTH     = 4096,
    parameter int MAX_BLOCK_FRAMES = 4096
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  aopt_pkg::t_cfg    i_cfg,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  aopt_pkg::t_in_word i_in_word,
    output logic              o_job_valid,
    input  logic              i_job_ready,
    output aopt_pkg::t_job    o_job
);
    localparam int AW = $clog2(WINDOW_DEPTH);
    localparam int LW = $clog2(WINDOW_DEPTH + 1);
    localparam int FW = $clog2(MAX_BLOCK_FRAMES);

    typedef enum logic [2:0] {F_CLR, F_IDLE, F_SQ, F_ACC, F_SWEEP, F_PUSH} t_fstate;

    t_fstate              r_state;
    logic [AW-1:0]        r_clr_addr;
    logic [AW-1:0]        r_pos;
    logic signed [24:0]   r_s;
    logic                 r_end;
    logic [37:0]          r_sq;
    logic [aopt_pkg::SUM_W-1:0] r_sum;
    logic [FW-1:0]        r_fc;
    aopt_pkg::t_job       r_job;
    logic [LW-1:0]        r_iss;
    logic                 r_dv;
    logic                 r_dnz;
    logic                 r_prev;
    logic [LW-1:0]        r_flips;

    logic [16:0]          wl17;
    logic [16:0]          lclamp;
    logic [LW-1:0]        wlen;
    logic signed [49:0]   sq_full;
    logic [LW:0]          pos_inc;
    logic [aopt_pkg::SUM_W:0] sum_add;
    logic [aopt_pkg::SUM_W-1:0] sum_sat;
    logic                 close;
    logic                 ram_we;
    logic [AW-1:0]        ram_waddr;
    logic                 ram_wdata;
    logic                 ram_rdata;

    always_comb begin
        wl17 = 17'(i_cfg.window_length);
        if (wl17 < 17'd2) begin
            lclamp = 17'd2;
        end else if (wl17 > 17'(WINDOW_DEPTH)) begin
            lclamp = 17'(WINDOW_DEPTH);
        end else begin
            lclamp = wl17;
        end
        wlen    = LW'(lclamp);
        sq_full = r_s * r_s;
        pos_inc = (LW + 1)'(r_pos) + (LW + 1)'(1);
        sum_add = {1'b0, r_sum} + (aopt_pkg::SUM_W + 1)'(r_sq);
        sum_sat = sum_add[aopt_pkg::SUM_W] ? '1 : sum_add[aopt_pkg::SUM_W-1:0];
        close   = r_end ||
                  ((FW + 1)'(r_fc) + (FW + 1)'(1) >= (FW + 1)'(MAX_BLOCK_FRAMES));
        ram_we    = (r_state == F_CLR) || (r_state == F_SQ);
        ram_waddr = (r_state == F_CLR) ? r_clr_addr : r_pos;
        ram_wdata = (r_state == F_CLR) ? 1'b0 : r_s[24];
    end

    aopt_ram #(.WIDTH(1), .DEPTH(WINDOW_DEPTH)) u_win (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (r_iss[AW-1:0]),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= F_CLR;
            r_clr_addr <= '0;
            r_pos      <= '0;
            r_sum      <= '0;
            r_fc       <= '0;
            r_dv       <= 1'b0;
        end else begin
            unique case (r_state)
                F_CLR: begin
                    r_clr_addr <= r_clr_addr + AW'(1);
                    if (r_clr_addr == AW'(WINDOW_DEPTH - 1)) begin
                        r_state <= F_IDLE;
                    end
                end
                F_IDLE: begin
                    if (i_in_valid) begin
                        r_s <= $signed({i_in_word.left_sample[23], i_in_word.left_sample})
                             + $signed({i_in_word.right_sample[23], i_in_word.right_sample});
                        r_end   <= i_in_word.block_end;
                        r_state <= F_SQ;
                    end
                end
                F_SQ: begin
                    r_sq    <= sq_full[49:12];
                    r_pos   <= (pos_inc >= (LW + 1)'(wlen)) ? '0 : pos_inc[AW-1:0];
                    r_state <= F_ACC;
                end
                F_ACC: begin
                    if (!close) begin
                        r_sum   <= sum_sat;
                        r_fc    <= r_fc + FW'(1);
                        r_state <= F_IDLE;
                    end else begin
                        r_job.sum   <= sum_sat;
                        r_job.n     <= aopt_pkg::FRM_W'(r_fc) + aopt_pkg::FRM_W'(1);
                        r_job.wlen  <= aopt_pkg::CNT_W'(wlen);
                        r_job.flips <= '0;
                        r_sum       <= '0;
                        r_fc        <= '0;
                        r_iss       <= '0;
                        r_dv        <= 1'b0;
                        r_flips     <= '0;
                        r_state     <= (i_cfg.morph_amount > 17'd655) ? F_SWEEP : F_PUSH;
                    end
                end
                F_SWEEP: begin
                    r_dv  <= (r_iss < wlen);
                    r_dnz <= (r_iss != '0);
                    if (r_iss < wlen) begin
                        r_iss <= r_iss + LW'(1);
                    end
                    if (r_dv) begin
                        r_prev <= ram_rdata;
                        if (r_dnz && (ram_rdata != r_prev)) begin
                            r_flips <= r_flips + LW'(1);
                        end
                    end else if (r_iss == wlen) begin
                        r_job.flips <= aopt_pkg::CNT_W'(r_flips);
                        r_state     <= F_PUSH;
                    end
                end
                F_PUSH: begin
                    if (i_job_ready) begin
                        r_state <= F_IDLE;
                    end
                end
                default: r_state <= F_IDLE;
            endcase
        end
    end

    assign o_in_ready  = (r_state == F_IDLE);
    assign o_job_valid = (r_state == F_PUSH);
    assign o_job       = r_job;
endmodule

### design/aopt_fifo.sv
// Two-entry job queue between front and back end.
// Uses aopt_pkg.
module aopt_fifo (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_wr_valid,
    output logic           o_wr_ready,
    input  aopt_pkg::t_job i_wr_job,
    output logic           o_rd_valid,
    input  logic           i_rd_ready,
    output aopt_pkg::t_job o_rd_job
);
    aopt_pkg::t_job r_mem [2];
    logic           r_wp;
    logic           r_rp;
    logic [1:0]     r_cnt;
    logic           push;
    logic           pop;

    assign o_wr_ready = (r_cnt != 2'd2);
    assign o_rd_valid = (r_cnt != 2'd0);
    assign o_rd_job   = r_mem[r_rp];
    assign push       = i_wr_valid && o_wr_ready;
    assign pop        = o_rd_valid && i_rd_ready;

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wp] <= i_wr_job;
        end
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) begin
                r_wp <= ~r_wp;
            end
            if (pop) begin
                r_rp <= ~r_rp;
            end
            if (push && !pop) begin
                r_cnt <= r_cnt + 2'd1;
            end else if (pop && !push) begin
                r_cnt <= r_cnt - 2'd1;
            end
        end
    end
endmodule

### design/aopt_back.sv
// Back end: block level, smoothing, onset test, pitch note and event output.
// Uses aopt_pkg.
module aopt_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  aopt_pkg::t_cfg     i_cfg,
    input  logic               i_job_valid,
    output logic               o_job_ready,
    input  aopt_pkg::t_job     i_job,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output aopt_pkg::t_out_word o_out_word
);
    typedef enum logic [3:0] {
        B_IDLE, B_DIV, B_SQRT, B_SM1, B_SM2, B_SM3, B_PR1, B_PR2,
        B_ONS, B_PIT, B_TGT, B_EVT, B_EMIT
    } t_bstate;

    t_bstate        r_state;
    aopt_pkg::t_job r_job;
    logic [5:0]     r_cnt;
    logic [47:0]    r_quo;
    logic [13:0]    r_rem;
    logic [59:0]    r_rad;
    logic [29:0]    r_root;
    logic [31:0]    r_srem;
    logic [23:0]    r_level;
    logic [23:0]    r_sm;
    logic [23:0]    r_prev;
    logic           r_act;
    logic [6:0]     r_anote;
    logic [40:0]    r_pa;
    logic [46:0]    r_pb;
    logic [33:0]    r_pp;
    logic [28:0]    r_lv20;
    logic           r_dpos;
    logic [23:0]    r_dmag;
    logic           r_onset;
    logic [16:0]    r_vel;
    logic [6:0]     r_base;
    logic [6:0]     r_det;
    logic [6:0]     r_tgt;
    logic [3:0]     r_k;
    logic [2:0]     r_oct;
    logic [2:0]     r_f;
    logic [6:0]     r_old;
    logic [6:0]     r_n2;
    logic           r_ovalid;
    aopt_pkg::t_out_word r_oword;

    logic [16:0]    ex;
    logic [16:0]    mo;
    logic [16:0]    bs;
    logic [14:0]    rem2;
    logic [33:0]    srm;
    logic [33:0]    strial;
    logic [23:0]    thr;
    logic [39:0]    sm_sum;
    logic [21:0]    vel_raw;
    logic [38:0]    edge_l;
    logic [49:0]    rhs;
    logic [24:0]    tgt_sum;
    logic [22:0]    bs60;
    logic           onset;
    logic           slot_free;
    logic           emit;

    always_comb begin
        ex      = (i_cfg.excite_level > 17'd65536) ? 17'd65536 : i_cfg.excite_level;
        mo      = (i_cfg.morph_amount > 17'd65536) ? 17'd65536 : i_cfg.morph_amount;
        bs      = (i_cfg.body_size > 17'd65536) ? 17'd65536 : i_cfg.body_size;
        rem2    = {r_rem, r_quo[47]};
        srm     = {r_srem, r_rad[59:58]};
        strial  = {2'b00, r_root, 2'b01};
        thr     = 24'd83886 + {1'b0, r_sm[23:1]};
        sm_sum  = 40'(r_pa) + 40'(r_pb) + 40'd32768;
        vel_raw = r_pb[46:25];
        edge_l  = 39'(aopt_pkg::note_edge(r_k)) * 39'(r_job.wlen);
        rhs     = 50'(edge_l) << (r_oct + 3'd1);
        tgt_sum = 25'(r_base) * 25'(17'd65536 - mo) + 25'(r_det) * 25'(mo) + 25'd32768;
        bs60    = 23'(bs) * 23'd60;
        onset   = r_dpos && ({1'b0, r_dmag, 16'b0} > r_pa) &&
                  ({r_level, 16'b0} > 40'(33'd33554 * 33'(ex)));
        slot_free = !r_ovalid || i_out_ready;
        emit      = (r_state == B_EMIT) && slot_free && (r_f != 3'b000);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= B_IDLE;
            r_sm     <= '0;
            r_prev   <= '0;
            r_act    <= 1'b0;
            r_anote  <= 7'd60;
            r_ovalid <= 1'b0;
        end else begin
            if (emit) begin
                r_ovalid <= 1'b1;
            end else if (r_ovalid && i_out_ready) begin
                r_ovalid <= 1'b0;
            end
            unique case (r_state)
                B_IDLE: begin
                    if (i_job_valid) begin
                        r_job   <= i_job;
                        r_quo   <= i_job.sum;
                        r_rem   <= '0;
                        r_cnt   <= '0;
                        r_srem  <= '0;
                        r_root  <= '0;
                        r_state <= B_DIV;
                    end
                end
                B_DIV: begin
                    if (rem2 >= 15'(r_job.n)) begin
                        r_rem <= 14'(rem2 - 15'(r_job.n));
                        r_quo <= {r_quo[46:0], 1'b1};
                    end else begin
                        r_rem <= rem2[13:0];
                        r_quo <= {r_quo[46:0], 1'b0};
                    end
                    if (r_cnt == 6'd47) begin
                        r_cnt   <= '0;
                        r_state <= B_SQRT;
                    end else begin
                        r_cnt <= r_cnt + 6'd1;
                    end
                end
                B_SQRT: begin
                    r_cnt <= r_cnt + 6'd1;
                    if (r_cnt == 6'd0) begin
                        r_rad <= {r_quo, 12'b0};
                    end else begin
                        r_rad <= {r_rad[57:0], 2'b00};
                        if (srm >= strial) begin
                            r_srem <= 32'(srm - strial);
                            r_root <= {r_root[28:0], 1'b1};
                        end else begin
                            r_srem <= srm[31:0];
                            r_root <= {r_root[28:0], 1'b0};
                        end
                    end
                    if (r_cnt == 6'd30) begin
                        r_state <= B_SM1;
                    end
                end
                B_SM1: begin
                    r_level <= (r_root > 30'hFFFFFF) ? 24'hFFFFFF : r_root[23:0];
                    r_pa    <= 41'(r_sm) * 41'(16'd62259);
                    r_srem  <= '0;
                    r_root  <= '0;
                    r_state <= B_SM2;
                end
                B_SM2: begin
                    r_pb    <= 47'(r_level) * 47'(12'd3277);
                    r_state <= B_SM3;
                end
                B_SM3: begin
                    r_sm    <= sm_sum[39:16];
                    r_dpos  <= r_level > r_prev;
                    r_dmag  <= r_level - r_prev;
                    r_prev  <= r_level;
                    r_pp    <= 34'(r_job.flips) * 34'(i_cfg.sample_rate_hz);
                    r_state <= B_PR1;
                end
                B_PR1: begin
                    r_pa    <= 41'(thr) * 41'(ex);
                    r_lv20  <= 29'(r_level) * 29'd20;
                    r_state <= B_PR2;
                end
                B_PR2: begin
                    r_pb    <= 47'(r_lv20) * 47'(18'd65536 + 18'(ex));
                    r_state <= B_ONS;
                end
                B_ONS: begin
                    r_onset <= onset;
                    if (vel_raw > 22'd65536) begin
                        r_vel <= 17'd65536;
                    end else if (vel_raw < 22'd6554) begin
                        r_vel <= 17'd6554;
                    end else begin
                        r_vel <= vel_raw[16:0];
                    end
                    r_base <= 7'd36 + 7'(bs60[22:16]);
                    r_det  <= 7'd35;
                    r_k    <= '0;
                    r_oct  <= '0;
                    if (mo > 17'd655) begin
                        r_state <= B_PIT;
                    end else begin
                        r_tgt   <= 7'd36 + 7'(bs60[22:16]);
                        r_state <= B_EVT;
                    end
                end
                B_PIT: begin
                    if ({r_pp, 16'b0} >= rhs) begin
                        r_det <= r_det + 7'd1;
                    end
                    if (r_k == 4'd11) begin
                        r_k   <= '0;
                        r_oct <= r_oct + 3'd1;
                        if (r_oct == 3'd4) begin
                            r_state <= B_TGT;
                        end
                    end else begin
                        r_k <= r_k + 4'd1;
                    end
                end
                B_TGT: begin
                    r_tgt   <= tgt_sum[22:16];
                    r_state <= B_EVT;
                end
                B_EVT: begin
                    r_f[0] <= r_onset && r_act;
                    r_f[1] <= r_onset;
                    r_f[2] <= (r_onset || r_act) && (r_sm <= 24'd16777);
                    r_old  <= r_anote;
                    r_n2   <= r_onset ? r_tgt : r_anote;
                    if (r_onset) begin
                        r_anote <= r_tgt;
                    end
                    r_act   <= (r_onset || r_act) && !(r_sm <= 24'd16777);
                    r_state <= B_EMIT;
                end
                B_EMIT: begin
                    if (slot_free) begin
                        priority if (r_f[0]) begin
                            r_oword  <= '{aopt_pkg::EV_OFF, r_old, 17'd0, !(r_f[1] || r_f[2])};
                            r_f[0]   <= 1'b0;
                        end else if (r_f[1]) begin
                            r_oword  <= '{aopt_pkg::EV_ON, r_tgt, r_vel, !r_f[2]};
                            r_f[1]   <= 1'b0;
                        end else if (r_f[2]) begin
                            r_oword  <= '{aopt_pkg::EV_OFF, r_n2, 17'd0, 1'b1};
                            r_f[2]   <= 1'b0;
                        end else begin
                            r_state <= B_IDLE;
                        end
                    end
                end
                default: r_state <= B_IDLE;
            endcase
        end
    end

    assign o_job_ready = (r_state == B_IDLE);
    assign o_out_valid = r_ovalid;
    assign o_out_word  = r_oword;
endmodule

### design/audio_onset_pitch_note_trigger.sv
// Top level of the onset-triggered note generator: APB registers, front end,
// job queue and back end. Uses aopt_pkg, aopt_front, aopt_fifo, aopt_back.
//
// Input channel: one stereo frame word (left, right, block_end) per valid/ready
// handshake. Output channel: note event words, zero to three per block.
// In the front end a frame goes through capture, square and window write, and
// accumulate. At block close with morph above 655 the front end reads the
// whole sign window once through the window RAM's single read port, then
// queues a job. The back end runs a 48-step divider, a square root and
// multiply steps per block, a pitch compare when morph is active, then emits
// its event words, and overlaps the next block's frames through a two-deep
// job queue. After reset the sign window is cleared one entry a cycle with
// input ready low; register writes are taken throughout.
// When the receiver stalls, one event word waits in the output register; the
// back end then holds, the queue fills and finally the input stops.
module audio_onset_pitch_note_trigger #(
    parameter int WINDOW_DEPTH     = 4096,
    parameter int MAX_BLOCK_FRAMES = 4096
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  aopt_pkg::t_in_word  i_in_word,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output aopt_pkg::t_out_word o_out_word,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [4:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);
    aopt_pkg::t_cfg r_cfg;
    logic           fj_valid;
    logic           fj_ready;
    aopt_pkg::t_job fj_job;
    logic           bj_valid;
    logic           bj_ready;
    aopt_pkg::t_job bj_job;
    logic [2:0]     reg_idx;

    assign reg_idx = paddr[4:2];
    assign pready  = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.body_size      <= 17'd32768;
            r_cfg.excite_level   <= 17'd32768;
            r_cfg.morph_amount   <= 17'd0;
            r_cfg.sample_rate_hz <= 18'd48000;
            r_cfg.window_length  <= 13'd4096;
        end else if (psel && penable && pwrite) begin
            unique case (reg_idx)
                aopt_pkg::REG_BODY:  r_cfg.body_size      <= pwdata[16:0];
                aopt_pkg::REG_EXC:   r_cfg.excite_level   <= pwdata[16:0];
                aopt_pkg::REG_MORPH: r_cfg.morph_amount   <= pwdata[16:0];
                aopt_pkg::REG_SRATE: r_cfg.sample_rate_hz <= pwdata[17:0];
                aopt_pkg::REG_WLEN:  r_cfg.window_length  <= pwdata[12:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            aopt_pkg::REG_BODY:  prdata = 32'(r_cfg.body_size);
            aopt_pkg::REG_EXC:   prdata = 32'(r_cfg.excite_level);
            aopt_pkg::REG_MORPH: prdata = 32'(r_cfg.morph_amount);
            aopt_pkg::REG_SRATE: prdata = 32'(r_cfg.sample_rate_hz);
            aopt_pkg::REG_WLEN:  prdata = 32'(r_cfg.window_length);
            default:             prdata = 32'd0;
        endcase
    end

    aopt_front #(
        .WINDOW_DEPTH     (WINDOW_DEPTH),
        .MAX_BLOCK_FRAMES (MAX_BLOCK_FRAMES)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_word   (i_in_word),
        .o_job_valid (fj_valid),
        .i_job_ready (fj_ready),
        .o_job       (fj_job)
    );

    aopt_fifo u_fifo (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_valid (fj_valid),
        .o_wr_ready (fj_ready),
        .i_wr_job   (fj_job),
        .o_rd_valid (bj_valid),
        .i_rd_ready (bj_ready),
        .o_rd_job   (bj_job)
    );

    aopt_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_job_valid (bj_valid),
        .o_job_ready (bj_ready),
        .i_job       (bj_job),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_word  (o_out_word)
    );
endmodule

### dv/audio_onset_pitch_note_trigger_test.sv
// Self-checking testbench for audio_onset_pitch_note_trigger: random bursts of
// stereo frames, an event predictor and an in-order event checker.
// Depends on aopt_pkg and the RTL of the block; nothing else.
module audio_onset_pitch_note_trigger_test;

    localparam int WIN_DEPTH   = 4096;
    localparam int FRAME_LIMIT = 4096;
    localparam logic [2:0] REG_NONE = 3'd5;
    localparam int SETTLE_CYC = 5000;

    logic i_clk;
    logic i_rst_n;
    logic i_in_valid;
    logic o_in_ready;
    aopt_pkg::t_in_word i_in_word;
    logic o_out_valid;
    logic i_out_ready;
    aopt_pkg::t_out_word o_out_word;
    logic psel, penable, pwrite;
    logic [4:0] paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic pready;

    audio_onset_pitch_note_trigger dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_ready(o_in_ready), .i_in_word(i_in_word),
        .o_out_valid(o_out_valid), .i_out_ready(i_out_ready), .o_out_word(o_out_word),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    // lower rounding edges of notes 36..47, Hz in Q.16
    longint edge_hz[12] = '{4164446, 4412077, 4674432, 4952388, 5246873, 5558868,
                            5889416, 6239618, 6610645, 7003735, 7420199, 7861427};

    // predicted block state
    bit     sign_hist[WIN_DEPTH];
    longint win_pos, energy_acc, frame_cnt, smooth_lvl, prev_lvl, held_note;
    bit     note_on;
    longint body_r, excite_r, morph_r, srate_r, wlen_r;

    aopt_pkg::t_in_word  frame_q[$];
    aopt_pkg::t_out_word event_q[$];
    int n_pushed, n_taken, n_errors;
    bit took;
    int burst_left, gap_left, stall_left, mode_left, rx_mode;

    initial begin
        i_clk = 0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #80000000;
        $display("audio_onset_pitch_note_trigger_test: FAIL");
        $finish;
    end

    function automatic longint sat16(longint v);
        return (v > 65536) ? 65536 : v;
    endfunction

    function automatic longint isqrt(longint v);
        longint r, b;
        r = 0;
        b = longint'(1) << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic longint win_len();
        return (wlen_r < 2) ? 2 : (wlen_r > WIN_DEPTH) ? WIN_DEPTH : wlen_r;
    endfunction

    function automatic longint pitch_guess();
        longint len, flips, note, lhs, rhs;
        len = win_len();
        flips = 0;
        note = 35;
        for (int i = 1; i < len; i++)
            if (sign_hist[i] != sign_hist[i-1]) flips++;
        lhs = (flips * srate_r) << 16;
        for (int o = 0; o < 5; o++)
            for (int k = 0; k < 12; k++) begin
                rhs = (edge_hz[k] << o) * 2 * len;
                if (lhs >= rhs) note++;
            end
        return note;
    endfunction

    function automatic aopt_pkg::t_out_word mk_event(logic kind, longint note, longint vel);
        aopt_pkg::t_out_word e;
        e.event_kind = kind;
        e.note_number = note[6:0];
        e.note_velocity = vel[16:0];
        e.last_event = 1'b0;
        return e;
    endfunction

    task automatic predict_events(aopt_pkg::t_in_word w);
        longint sl, sr, s, len, n, lvl, delta, thr, ex, mo, base, target, vel;
        aopt_pkg::t_out_word ev[$];
        sl = w.left_sample;
        sr = w.right_sample;
        s = sl + sr;
        len = win_len();
        if (win_pos >= WIN_DEPTH) win_pos = 0;
        sign_hist[win_pos] = (s < 0);
        win_pos = (win_pos + 1 >= len) ? 0 : win_pos + 1;
        energy_acc += (s * s) >>> 12;
        if (energy_acc > (longint'(1) << 48) - 1) energy_acc = (longint'(1) << 48) - 1;
        if (!w.block_end && frame_cnt + 1 < FRAME_LIMIT) begin
            frame_cnt++;
            return;
        end
        n = frame_cnt + 1;
        lvl = isqrt((energy_acc / n) << 12);
        energy_acc = 0;
        frame_cnt = 0;
        if (lvl > 24'hFFFFFF) lvl = 24'hFFFFFF;
        smooth_lvl = (smooth_lvl * 62259 + lvl * 3277 + 32768) >> 16;
        delta = lvl - prev_lvl;
        prev_lvl = lvl;
        thr = 83886 + (smooth_lvl >> 1);
        ex = sat16(excite_r);
        mo = sat16(morph_r);
        base = 36 + ((sat16(body_r) * 60) >> 16);
        target = base;
        if (mo > 655)
            target = (base * (65536 - mo) + pitch_guess() * mo + 32768) >> 16;
        if (delta * 65536 > thr * ex && lvl * 65536 > 33554 * ex) begin
            if (note_on) ev.push_back(mk_event(aopt_pkg::EV_OFF, held_note, 0));
            vel = (lvl * 20 * (65536 + ex)) >> 25;
            if (vel > 65536) vel = 65536;
            if (vel < 6554) vel = 6554;
            ev.push_back(mk_event(aopt_pkg::EV_ON, target, vel));
            held_note = target & 127;
            note_on = 1;
        end
        if (note_on && smooth_lvl <= 16777) begin
            ev.push_back(mk_event(aopt_pkg::EV_OFF, held_note, 0));
            note_on = 0;
        end
        if (ev.size() > 0) ev[ev.size()-1].last_event = 1'b1;
        foreach (ev[i]) event_q.push_back(ev[i]);
    endtask

    task automatic report(string msg);
        $display("mismatch @%0t: %s", $time, msg);
        n_errors++;
    endtask

    task automatic check_event(aopt_pkg::t_out_word got);
        aopt_pkg::t_out_word want;
        if (event_q.size() == 0) begin
            report($sformatf("unexpected event word %h", got));
            return;
        end
        want = event_q.pop_front();
        if (got.event_kind !== want.event_kind)
            report($sformatf("event_kind %0d, want %0d", got.event_kind, want.event_kind));
        if (got.note_number !== want.note_number)
            report($sformatf("note_number %0d, want %0d", got.note_number, want.note_number));
        if (got.note_velocity !== want.note_velocity)
            report($sformatf("note_velocity %0d, want %0d",
                             got.note_velocity, want.note_velocity));
        if (got.last_event !== want.last_event)
            report($sformatf("last_event %0d, want %0d", got.last_event, want.last_event));
    endtask

    // monitor: input acceptance feeds the predictor, output words are checked
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready) check_event(o_out_word);
            if (i_in_valid && o_in_ready) begin
                predict_events(i_in_word);
                n_taken++;
                took = 1;
            end
        end
    end

    // driver: bursts with random gaps
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || took) begin
            took = 0;
            if (gap_left > 0) begin
                gap_left--;
                i_in_valid <= 1'b0;
            end else if (frame_q.size() > 0) begin
                i_in_word <= frame_q.pop_front();
                i_in_valid <= 1'b1;
                if (burst_left > 0) begin
                    burst_left--;
                end else begin
                    burst_left = $urandom_range(0, 24);
                    gap_left = $urandom_range(0, 1) ? $urandom_range(1, 8) : 0;
                end
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // receiver: always ready, random, or occasional long stalls
    always @(negedge i_clk) begin
        if (mode_left == 0) begin
            rx_mode = $urandom_range(0, 2);
            mode_left = $urandom_range(200, 600);
        end else begin
            mode_left--;
        end
        if (stall_left > 0) begin
            stall_left--;
            i_out_ready <= 1'b0;
        end else if (rx_mode == 1) begin
            i_out_ready <= ($urandom_range(0, 99) < 60);
        end else if (rx_mode == 2 && $urandom_range(0, 99) < 3) begin
            stall_left = $urandom_range(1, 30);
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    task automatic reg_write(logic [2:0] idx, longint val);
        @(negedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= val[31:0];
        @(negedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        unique case (idx)
            aopt_pkg::REG_BODY:  body_r = val & 17'h1FFFF;
            aopt_pkg::REG_EXC:   excite_r = val & 17'h1FFFF;
            aopt_pkg::REG_MORPH: morph_r = val & 17'h1FFFF;
            aopt_pkg::REG_SRATE: srate_r = val & 18'h3FFFF;
            aopt_pkg::REG_WLEN:  wlen_r = val & 13'h1FFF;
            default: ;
        endcase
    endtask

    task automatic set_regs(longint b, longint e, longint m, longint sr, longint wl);
        reg_write(aopt_pkg::REG_BODY, b);
        reg_write(aopt_pkg::REG_EXC, e);
        reg_write(aopt_pkg::REG_MORPH, m);
        reg_write(aopt_pkg::REG_SRATE, sr);
        reg_write(aopt_pkg::REG_WLEN, wl);
        reg_write(REG_NONE, $urandom);
    endtask

    task automatic push(longint l, longint r, bit be);
        aopt_pkg::t_in_word w;
        w.left_sample = l[23:0];
        w.right_sample = r[23:0];
        w.block_end = be;
        frame_q.push_back(w);
        n_pushed++;
    endtask

    task automatic push_block();
        int kind, nfr, per;
        longint amp, v;
        kind = $urandom_range(0, 9);
        nfr = $urandom_range(1, (kind < 4) ? 4 : 6);
        per = $urandom_range(1, 8);
        amp = $urandom_range(1 << 20, 8388607);
        for (int i = 0; i < nfr; i++) begin
            if (kind < 4) begin
                v = ((i / per) % 2) ? -amp : amp;
                push(v, $urandom_range(0, 1) ? v : longint'($urandom_range(0, 65535)) - 32768,
                     i == nfr - 1);
            end else if (kind < 7) begin
                push(longint'($urandom_range(0, 4000)) - 2000,
                     longint'($urandom_range(0, 4000)) - 2000, i == nfr - 1);
            end else if (kind < 9) begin
                push($signed($urandom_range(0, 24'hFFFFFF) << 8) >>> 8,
                     $signed($urandom_range(0, 24'hFFFFFF) << 8) >>> 8,
                     $urandom_range(0, 3) == 0);
            end else begin
                push(0, 0, i == nfr - 1);
            end
        end
    endtask

    task automatic drain();
        while (n_taken != n_pushed) @(posedge i_clk);
        while (event_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYC) @(posedge i_clk);
    endtask

    task automatic random_phase(int items);
        int goal;
        goal = n_pushed + items;
        while (n_pushed < goal) push_block();
        drain();
    endtask

    initial begin
        i_rst_n = 0;
        i_in_valid = 0;
        i_in_word = '0;
        i_out_ready = 0;
        psel = 0;
        penable = 0;
        pwrite = 0;
        paddr = '0;
        pwdata = '0;
        took = 0;
        n_pushed = 0;
        n_taken = 0;
        n_errors = 0;
        burst_left = 0;
        gap_left = 0;
        stall_left = 0;
        mode_left = 0;
        rx_mode = 0;
        foreach (sign_hist[i]) sign_hist[i] = 0;
        win_pos = 0;
        energy_acc = 0;
        frame_cnt = 0;
        smooth_lvl = 0;
        prev_lvl = 0;
        note_on = 0;
        held_note = 60;
        body_r = 32768;
        excite_r = 32768;
        morph_r = 0;
        srate_r = 48000;
        wlen_r = 4096;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1;

        // extremes, onset and silence note-off
        set_regs(65536, 0, 65536, 48000, 64);
        push(-8388608, -8388608, 1);
        push(8388607, 8388607, 1);
        push(-8388608, 8388607, 1);
        push(0, 0, 1);
        push(-1, 0, 0);
        push(1, 1, 1);
        push(8388607, -8388608, 0);
        push(-8388608, -8388608, 1);
        for (int i = 0; i < 6; i++) push(0, 0, 1);
        push(4000000, 4000000, 1);
        drain();

        // longer block over a two-entry window
        set_regs(0, 32768, 656, 192000, 2);
        for (int i = 0; i < 40; i++)
            push(longint'($urandom_range(0, 2000)) - 1000, 500, 0);
        push(3000000, -3000000, 1);
        drain();

        set_regs(131071, 131071, 655, 8000, 0);
        random_phase(40);
        set_regs(32768, 16384, 131071, 0, 8191);
        random_phase(30);
        set_regs(20000, 0, 40000, 262143, 1);
        random_phase(50);
        set_regs($urandom_range(0, 65536), 8000, 65536, 44100, 256);
        while (n_pushed < 240)
            random_phase(20);

        if (n_errors == 0) begin
            $display("audio_onset_pitch_note_trigger_test: PASS");
        end else begin
            $display("audio_onset_pitch_note_trigger_test: FAIL");
        end
        $finish;
    end
endmodule
